[hdl/edb_pkg.sv]
package edb_pkg;

  localparam int COUNT_W    = 32;
  localparam int TARGET_W   = 32;
  localparam int LIMIT_W    = 11;
  localparam int NUM_W      = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LIMIT = 1'b1;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 32'd1;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

[hdl/edb_if.sv]
interface edb_in_if #(
  parameter int KW = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KW-1:0]        key_value;
  logic [edb_pkg::COUNT_W-1:0] item_count;
  logic                        last_item;

  modport source (output valid, key_value, item_count, last_item, input ready);
  modport sink   (input valid, key_value, item_count, last_item, output ready);
endinterface

interface edb_out_if #(
  parameter int KW = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KW-1:0]        bucket_low;
  logic signed [KW-1:0]        bucket_high;
  logic [edb_pkg::COUNT_W-1:0] bucket_depth;
  logic [edb_pkg::NUM_W-1:0]   bucket_number;
  logic                        final_bucket;

  modport source (output valid, bucket_low, bucket_high, bucket_depth, bucket_number,
                  final_bucket, input ready);
  modport sink   (input valid, bucket_low, bucket_high, bucket_depth, bucket_number,
                  final_bucket, output ready);
endinterface

[hdl/edb_core.sv]
module edb_core #(
  parameter int MAX_BUCKETS = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int RW          = 2 * KEY_WIDTH + edb_pkg::COUNT_W + edb_pkg::NUM_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [edb_pkg::TARGET_W-1:0] target_r,
  input  logic [edb_pkg::LIMIT_W-1:0]  limit_r,
  input  logic                         acc,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [edb_pkg::COUNT_W-1:0]  cnt,
  input  logic                         last,
  output edb_pkg::push_t               push,
  output logic [RW-1:0]                res0,
  output logic [RW-1:0]                res1
);

  localparam int EW = $clog2(MAX_BUCKETS + 1);
  localparam int LW = (EW > edb_pkg::LIMIT_W) ? EW : edb_pkg::LIMIT_W;
  localparam int CW = edb_pkg::COUNT_W;
  localparam logic [LW-1:0] MAXB = LW'(MAX_BUCKETS);

  typedef struct packed {
    logic                 v;
    logic [KEY_WIDTH-1:0] lo;
    logic [KEY_WIDTH-1:0] hi;
    logic [CW-1:0]        dep;
  } emit_t;

  // True when the emitted count plus add leaves only the overflow bucket.
  function automatic logic is_ovf(input logic [EW-1:0] e, input logic [1:0] add,
                                  input logic [LW-1:0] lim);
    logic [LW+1:0] s;
    s = (LW+2)'(e) + (LW+2)'(add) + (LW+2)'(1);
    return s >= (LW+2)'(lim);
  endfunction

  logic                 open_r, open_nxt;
  logic [KEY_WIDTH-1:0] low_r, low_nxt;
  logic [KEY_WIDTH-1:0] prev_r, prev_nxt;
  logic [CW-1:0]        run_r, run_nxt;
  logic [EW-1:0]        emit_cnt_r, emit_cnt_nxt;

  logic [CW-1:0] tgt;
  logic [LW-1:0] lim_ext, lim;
  logic          ovf0, ovf1, ovf_f;
  logic [CW:0]   upper, over;
  logic [CW-1:0] under, upper_sat;
  logic          c_ge;
  logic [1:0]    n_pre;
  emit_t         em1, em2, emf, r0, r1;
  logic          fin0, fin1;

  assign tgt     = (target_r == '0) ? CW'(1) : target_r;
  assign lim_ext = LW'(limit_r);
  assign lim     = (lim_ext == '0) ? LW'(1) : ((lim_ext > MAXB) ? MAXB : lim_ext);

  assign upper     = {1'b0, run_r} + {1'b0, cnt};
  assign under     = tgt - run_r;
  assign over      = upper - {1'b0, tgt};
  assign upper_sat = upper[CW] ? '1 : upper[CW-1:0];
  assign c_ge      = cnt >= tgt;
  assign ovf0      = is_ovf(emit_cnt_r, 2'd0, lim);
  assign ovf1      = is_ovf(emit_cnt_r, 2'd1, lim);

  always_comb begin
    open_nxt = open_r;
    low_nxt  = low_r;
    prev_nxt = prev_r;
    run_nxt  = run_r;
    em1      = '0;
    em2      = '0;
    emf      = '0;
    if (!open_r) begin
      if (!ovf0 && c_ge) begin
        em1 = '{v: 1'b1, lo: key, hi: key, dep: cnt};
      end else begin
        open_nxt = 1'b1;
        low_nxt  = key;
        prev_nxt = key;
        run_nxt  = cnt;
      end
    end else if (ovf0) begin
      run_nxt  = upper_sat;
      prev_nxt = key;
    end else if (upper < {1'b0, tgt}) begin
      run_nxt  = upper[CW-1:0];
      prev_nxt = key;
    end else if (upper == {1'b0, tgt}) begin
      em1      = '{v: 1'b1, lo: low_r, hi: key, dep: upper[CW-1:0]};
      open_nxt = 1'b0;
      run_nxt  = '0;
    end else if (run_r <= tgt && {1'b0, under} <= over) begin
      // Closing before the crossing item is at least as close to the target.
      // A running depth already past the target always closes after the item.
      em1      = '{v: 1'b1, lo: low_r, hi: prev_r, dep: run_r};
      open_nxt = 1'b0;
      run_nxt  = '0;
      if (!ovf1 && c_ge) begin
        em2 = '{v: 1'b1, lo: key, hi: key, dep: cnt};
      end else begin
        open_nxt = 1'b1;
        low_nxt  = key;
        prev_nxt = key;
        run_nxt  = cnt;
      end
    end else begin
      em1      = '{v: 1'b1, lo: low_r, hi: key, dep: upper_sat};
      open_nxt = 1'b0;
      run_nxt  = '0;
    end

    n_pre = {1'b0, em1.v} + {1'b0, em2.v};
    ovf_f = is_ovf(emit_cnt_r, n_pre, lim);

    // An empty overflow bucket is dropped at the end of the stream.
    if (last && open_nxt && !(ovf_f && run_nxt == '0)) begin
      emf = '{v: 1'b1, lo: low_nxt, hi: prev_nxt, dep: run_nxt};
    end

    if (last) begin
      open_nxt     = 1'b0;
      run_nxt      = '0;
      emit_cnt_nxt = '0;
    end else begin
      emit_cnt_nxt = EW'({1'b0, emit_cnt_r} + (EW+1)'(n_pre));
    end
  end

  // A second emit only ever follows a first one.
  assign r0   = em1.v ? em1 : emf;
  assign r1   = em1.v ? (em2.v ? em2 : emf) : '0;
  assign fin1 = last && r1.v;
  assign fin0 = last && !r1.v;

  assign res0 = {r0.lo, r0.hi, r0.dep, edb_pkg::NUM_W'(emit_cnt_r), fin0};
  assign res1 = {r1.lo, r1.hi, r1.dep,
                 edb_pkg::NUM_W'({1'b0, emit_cnt_r} + (EW+1)'(1)), fin1};

  assign push.push0 = acc && r0.v;
  assign push.push1 = acc && r1.v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      run_r      <= '0;
      emit_cnt_r <= '0;
      low_r      <= '0;
      prev_r     <= '0;
    end else if (acc) begin
      open_r     <= open_nxt;
      run_r      <= run_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      low_r      <= low_nxt;
      prev_r     <= prev_nxt;
    end
  end

endmodule

[hdl/edb_fifo.sv]
module edb_fifo #(
  parameter int W = 107
) (
  input  logic           clk,
  input  logic           rst_n,
  input  edb_pkg::push_t push,
  input  logic [W-1:0]   din0,
  input  logic [W-1:0]   din1,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   dout
);

  logic [W-1:0]               mem [edb_pkg::Q_DEPTH];
  logic [edb_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [edb_pkg::Q_CW-1:0]   count_r, count_nxt;
  logic                       pop;
  logic [edb_pkg::Q_CW-1:0]   n_push;

  assign pop       = out_valid && out_ready;
  assign n_push    = edb_pkg::Q_CW'(push.push0) + edb_pkg::Q_CW'(push.push1);
  assign count_nxt = count_r + n_push - edb_pkg::Q_CW'(pop);
  assign out_valid = count_r != '0;
  assign dout      = mem[rd_ptr_r];
  // Room for the two results that one transaction can produce.
  assign space     = count_r <= edb_pkg::Q_CW'(edb_pkg::Q_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= din0;
    end
    if (push.push1) begin
      mem[wr_ptr_r + edb_pkg::Q_AW'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + edb_pkg::Q_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + edb_pkg::Q_AW'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

[hdl/equi_depth_bucket_builder.sv]
// Equi-depth bucket builder.
// in_bus carries sorted (key_value, item_count, last_item) items; out_bus carries one
// bucket per transaction: bucket_low, bucket_high, bucket_depth, bucket_number and
// final_bucket on the last bucket of a histogram.
// The cfg port writes target_depth (index 0) and bucket_limit (index 1);
// write it only while no results are pending.
// Each item is handled in the cycle it is accepted, against the running bucket state,
// and its results are written into a four-entry result queue. A bucket appears on
// out_bus from the queue's registers once the buckets ahead of it have been taken.
// Throughput is one item per cycle while in_bus.ready is high. An item that closes
// two buckets takes two output transactions, so the output channel sets the sustained
// rate at one bucket per cycle while out_bus.ready is high. in_bus.ready is high while
// the queue has room for two results; when the receiver stalls, in_bus.ready drops as
// soon as more than two results are waiting. Reset empties the queue, clears the bucket
// state and restores target_depth to 1 and bucket_limit to 1024.
module equi_depth_bucket_builder #(
  parameter int MAX_BUCKETS = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  edb_in_if.sink                         in_bus,
  edb_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [edb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = 2 * KEY_WIDTH + edb_pkg::COUNT_W + edb_pkg::NUM_W + 1;

  logic [edb_pkg::TARGET_W-1:0] target_r;
  logic [edb_pkg::LIMIT_W-1:0]  limit_r;
  logic                         acc;
  logic                         space;
  edb_pkg::push_t               push;
  logic [RW-1:0]                res0, res1, dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= edb_pkg::TARGET_RESET;
      limit_r  <= edb_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        edb_pkg::CFG_TARGET_DEPTH: target_r <= cfg_data[edb_pkg::TARGET_W-1:0];
        edb_pkg::CFG_BUCKET_LIMIT: limit_r  <= cfg_data[edb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_bus.ready = space;
  assign acc          = in_bus.valid && space;

  edb_core #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .KEY_WIDTH   (KEY_WIDTH),
    .RW          (RW)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .target_r (target_r),
    .limit_r  (limit_r),
    .acc      (acc),
    .key      (in_bus.key_value),
    .cnt      (in_bus.item_count),
    .last     (in_bus.last_item),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  edb_fifo #(
    .W (RW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .space     (space),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .dout      (dout)
  );

  assign {out_bus.bucket_low, out_bus.bucket_high, out_bus.bucket_depth,
          out_bus.bucket_number, out_bus.final_bucket} = dout;

endmodule

[hdl/edb_checker.sv]
module edb_checker #(
  parameter int KW = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [KW-1:0]               out_low,
  input logic [KW-1:0]               out_high,
  input logic [edb_pkg::COUNT_W-1:0] out_depth,
  input logic [edb_pkg::NUM_W-1:0]   out_number,
  input logic                        out_final
);

  // Reset leaves an empty result queue that can take input.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

  // Results only come from accepted transactions.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result appeared without an input transaction");

  // Backpressure on the input only happens when results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low) && $stable(out_high)
      && $stable(out_depth) && $stable(out_number) && $stable(out_final))
    else $error("stalled result changed");

endmodule

bind equi_depth_bucket_builder edb_checker #(.KW(KEY_WIDTH)) u_edb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_low    (out_bus.bucket_low),
  .out_high   (out_bus.bucket_high),
  .out_depth  (out_bus.bucket_depth),
  .out_number (out_bus.bucket_number),
  .out_final  (out_bus.final_bucket)
);
